FILE: sv/qsa_pkg.sv
// Package for the quaternary signature automaton: item types, codes and helpers.
`default_nettype none

package qsa_pkg;

  // Default sizes of the automaton.
  localparam int DEF_NODE_COUNT      = 65536;
  localparam int DEF_PATTERN_ID_BITS = 16;

  // Width that holds any node count in the supported range, plus one.
  localparam int NODE_EXT_W = 22;

  // Command codes of an input item.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;

  // One input item.
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] node_index;
    logic [15:0] next_for_sym0;
    logic [15:0] next_for_sym1;
    logic [15:0] next_for_sym2;
    logic [15:0] next_for_sym3;
    logic        is_terminal;
    logic [15:0] pattern_tag;
    logic [7:0]  data_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [15:0] match_id;
    logic [1:0]  symbol_slot;
    logic        last_of_byte;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;       // Load item accepted this cycle.
    logic       restart;    // Start item accepted this cycle.
    logic       capture;    // Data item accepted this cycle.
    logic       fetch;      // Read the row of the current node.
    logic       step;       // Take one symbol transition.
    logic [1:0] slot;       // Symbol slot of the step.
    logic       eval;       // Check the row just read for a match.
    logic [1:0] eval_slot;  // Symbol slot that reached that row.
    logic       flush;      // Send out the held match as last of the byte.
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic row_ok;  // Read register holds the current node's row.
  } dp_status_t;

  // Pick one 2-bit symbol of a byte, slot 0 being the high pair.
  function automatic logic [1:0] sym_of(logic [7:0] b, logic [1:0] s);
    logic [1:0] r;
    case (s)
      2'd0:    r = b[7:6];
      2'd1:    r = b[5:4];
      2'd2:    r = b[3:2];
      default: r = b[1:0];
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/qsa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module qsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/qsa_datapath.sv
// Datapath of the automaton: node table, current node, match holding and result register.
`default_nettype none

module qsa_datapath
  import qsa_pkg::*;
#(
  parameter int NODE_COUNT      = DEF_NODE_COUNT,
  parameter int PATTERN_ID_BITS = DEF_PATTERN_ID_BITS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire item_t      item_i,
  input  wire dp_cmd_t    cmd_i,
  output      dp_status_t status_o,
  output      logic       result_valid_o,
  output      result_t    result_o
);

  localparam int AW      = $clog2(NODE_COUNT);
  localparam int PW      = (PATTERN_ID_BITS < 16) ? PATTERN_ID_BITS : 16;
  localparam int TAG_LSB = 64;
  localparam int TERM_B  = 64 + PW;
  localparam int ROW_W   = 65 + PW;

  logic [AW-1:0]         cur_q, cur_d;
  logic                  row_ok_q, row_ok_d;
  logic [7:0]            byte_q, byte_d;
  logic                  pend_v_q, pend_v_d;
  logic [15:0]           pend_id_q, pend_id_d;
  logic [1:0]            pend_slot_q, pend_slot_d;
  logic                  res_v_q, res_v_d;
  result_t               res_q, res_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ROW_W-1:0]      ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [ROW_W-1:0]      row;

  logic [NODE_EXT_W-1:0] idx_ext;
  logic [NODE_EXT_W-1:0] nxt_ext;
  logic [15:0]           nxt_raw;
  logic [AW-1:0]         nxt;
  logic [1:0]            sym;
  logic                  term;
  logic [15:0]           row_id;

  // Node table: four next nodes, the pattern id and the terminal flag per row.
  qsa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NODE_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (row)
  );

  // Load writes are dropped when the node index is past the table.
  assign idx_ext   = NODE_EXT_W'(item_i.node_index);
  assign ram_we    = cmd_i.load && (idx_ext < NODE_EXT_W'(NODE_COUNT));
  assign ram_waddr = idx_ext[AW-1:0];
  assign ram_wdata = {item_i.is_terminal, item_i.pattern_tag[PW-1:0],
                      item_i.next_for_sym3, item_i.next_for_sym2,
                      item_i.next_for_sym1, item_i.next_for_sym0};

  // Next node for the current symbol; an entry past the table goes to the root.
  assign sym = sym_of(byte_q, cmd_i.slot);
  always_comb begin
    case (sym)
      2'd0:    nxt_raw = row[15:0];
      2'd1:    nxt_raw = row[31:16];
      2'd2:    nxt_raw = row[47:32];
      default: nxt_raw = row[63:48];
    endcase
  end
  assign nxt_ext = NODE_EXT_W'(nxt_raw);
  assign nxt     = (nxt_ext < NODE_EXT_W'(NODE_COUNT)) ? nxt_ext[AW-1:0] : '0;

  // One read per step; a fetch reads the current node's row first.
  assign ram_re    = cmd_i.fetch || cmd_i.step;
  assign ram_raddr = cmd_i.fetch ? cur_q : nxt;

  assign term   = row[TERM_B];
  assign row_id = 16'(row[TAG_LSB +: PW]);

  // Current node, row holding flag and the byte under scan.
  always_comb begin
    cur_d    = cur_q;
    row_ok_d = row_ok_q;
    byte_d   = byte_q;
    if (cmd_i.restart) begin
      cur_d    = '0;
      row_ok_d = 1'b0;
    end
    if (cmd_i.load) begin
      row_ok_d = 1'b0;
    end
    if (cmd_i.capture) begin
      byte_d = item_i.data_byte;
    end
    if (cmd_i.step) begin
      cur_d = nxt;
    end
    if (cmd_i.flush) begin
      row_ok_d = 1'b1;
    end
  end

  // A match is held until the next one or the end of the byte decides its last flag.
  always_comb begin
    pend_v_d    = pend_v_q;
    pend_id_d   = pend_id_q;
    pend_slot_d = pend_slot_q;
    res_v_d     = 1'b0;
    res_d       = res_q;
    if (cmd_i.eval && term) begin
      if (pend_v_q) begin
        res_v_d            = 1'b1;
        res_d.match_id     = pend_id_q;
        res_d.symbol_slot  = pend_slot_q;
        res_d.last_of_byte = 1'b0;
      end
      pend_v_d    = 1'b1;
      pend_id_d   = row_id;
      pend_slot_d = cmd_i.eval_slot;
    end
    if (cmd_i.flush) begin
      pend_v_d = 1'b0;
      if (pend_v_q) begin
        res_v_d            = 1'b1;
        res_d.match_id     = pend_id_q;
        res_d.symbol_slot  = pend_slot_q;
        res_d.last_of_byte = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      row_ok_q <= 1'b0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      cur_q    <= cur_d;
      row_ok_q <= row_ok_d;
      pend_v_q <= pend_v_d;
      res_v_q  <= res_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    pend_id_q   <= pend_id_d;
    pend_slot_q <= pend_slot_d;
    res_q       <= res_d;
  end

  assign status_o.row_ok = row_ok_q;
  assign result_valid_o  = res_v_q;
  assign result_o        = res_q;

`ifndef NO_ASSERTIONS
  // A result only follows a match check or the end of a byte.
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q |-> $past(cmd_i.eval || cmd_i.flush))
    else $error("result without a match check");

  // Nothing is held over into the next byte.
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> !pend_v_q)
    else $error("match held past end of byte");

  // A table write never meets a scan read.
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !ram_re)
    else $error("table write during scan");
`endif

endmodule

`default_nettype wire

FILE: sv/qsa_ctrl.sv
// Controller of the automaton: item acceptance and the per-byte symbol sequence.
`default_nettype none

module qsa_ctrl
  import qsa_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire logic [1:0] command_i,
  input  wire dp_status_t status_i,
  output      logic       busy,
  output      dp_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] slot_q, slot_d;
  logic       accept;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load    = accept && (command_i == CMD_LOAD);
        cmd_o.restart = accept && (command_i == CMD_START);
        cmd_o.capture = accept && (command_i == CMD_DATA);
        if (cmd_o.capture) begin
          slot_d  = 2'd0;
          state_d = status_i.row_ok ? S_STEP : S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_STEP;
      end
      S_STEP: begin
        cmd_o.step      = 1'b1;
        cmd_o.slot      = slot_q;
        cmd_o.eval      = (slot_q != 2'd0);
        cmd_o.eval_slot = slot_q - 2'd1;
        slot_d          = slot_q + 2'd1;
        if (slot_q == 2'd3) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval      = 1'b1;
        cmd_o.eval_slot = 2'd3;
        state_d         = S_FLUSH;
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A data item always starts a scan.
  a_data_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CMD_DATA) |=> busy)
    else $error("data item did not start a scan");

  // Load and start items never hold the block busy.
  a_ctrl_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i != CMD_DATA) |=> !busy)
    else $error("non-data item made the block busy");

  // The fourth step is followed by the final check.
  a_step_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP && slot_q == 2'd3) |=> (state_q == S_EVAL))
    else $error("symbol sequence out of order");
`endif

endmodule

`default_nettype wire

FILE: sv/quaternary_signature_automaton_top.sv
// Top level of the quaternary signature automaton.
//
//  Channel  Handshake               Payload    Direction
//  item     start, busy             item_i     in
//  result   result_valid_o strobe   result_o   out
//
// Load and start items take one cycle; busy stays low and the next item may follow at once.
// A data item holds busy high for 6 cycles, or 7 when the current node's row must be read
// first (after reset, a start or a load): one registered table read per symbol, each
// addressed by the previous read's data, then a final check and a drain of the held match.
// Results are one-cycle strobes on result_valid_o; the receiver cannot stall.
// Reset clears the control state only; the node table is filled by load items.
`default_nettype none

module quaternary_signature_automaton_top
  import qsa_pkg::*;
#(
  parameter int NODE_COUNT      = DEF_NODE_COUNT,
  parameter int PATTERN_ID_BITS = DEF_PATTERN_ID_BITS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  output      logic  busy,
  input  wire item_t item_i,
  output      logic  result_valid_o,
  output      result_t result_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer.
  qsa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (item_i.command),
    .status_i  (status),
    .busy      (busy),
    .cmd_o     (cmd)
  );

  // Table, current node and result path.
  qsa_datapath #(
    .NODE_COUNT      (NODE_COUNT),
    .PATTERN_ID_BITS (PATTERN_ID_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

FILE: test/quaternary_signature_automaton_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the quaternary signature automaton top level.
module quaternary_signature_automaton_top_tb;
  import qsa_pkg::*;

  localparam int         NODES        = DEF_NODE_COUNT;
  localparam int         ID_BITS      = DEF_PATTERN_ID_BITS;
  localparam bit [15:0]  ID_MASK      = 16'((64'd1 << ID_BITS) - 1);
  localparam logic [1:0] CMD_SPARE    = 2'd3;
  localparam int         RANDOM_ITEMS = 120;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         CYCLE_LIMIT  = 100000;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  item_t   item_i = '0;
  logic    busy;
  logic    result_valid_o;
  result_t result_o;

  quaternary_signature_automaton_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Predicted automaton: successor rows, pattern ids and the node being scanned.
  bit [15:0] succ_of   [0:NODES-1][0:3];
  bit        tag_valid [0:NODES-1];
  bit [15:0] tag_of    [0:NODES-1];
  bit [15:0] cur_node  = '0;

  item_t       queued_commands[$];
  result_t     predicted_matches[$];
  logic [15:0] live_nodes[$];
  bit          item_taken    = 1'b0;
  int          idle_left     = 0;
  int          calm_left     = 0;
  int          mismatch_count = 0;
  int unsigned cycle_count   = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Apply one accepted item to the predicted automaton and queue the matches it causes.
  task automatic walk_automaton(input item_t it);
    result_t    hits [0:3];
    int         n_hits;
    int         nxt;
    logic [1:0] sym;
    n_hits = 0;
    case (it.command)
      CMD_LOAD: begin
        if (int'(it.node_index) < NODES) begin
          succ_of[it.node_index][0] = it.next_for_sym0;
          succ_of[it.node_index][1] = it.next_for_sym1;
          succ_of[it.node_index][2] = it.next_for_sym2;
          succ_of[it.node_index][3] = it.next_for_sym3;
          tag_valid[it.node_index]  = it.is_terminal;
          tag_of[it.node_index]     = it.pattern_tag & ID_MASK;
        end
      end
      CMD_START: cur_node = '0;
      CMD_DATA: begin
        for (int s = 0; s < 4; s++) begin
          sym = 2'((it.data_byte >> (6 - 2 * s)) & 8'd3);
          nxt = int'(succ_of[cur_node][sym]);
          // A successor beyond the node range falls back to the root.
          if (nxt >= NODES) nxt = 0;
          cur_node = 16'(nxt);
          if (tag_valid[cur_node]) begin
            hits[n_hits].match_id     = tag_of[cur_node];
            hits[n_hits].symbol_slot  = 2'(s);
            hits[n_hits].last_of_byte = 1'b0;
            n_hits++;
          end
        end
        if (n_hits > 0) hits[n_hits - 1].last_of_byte = 1'b1;
        for (int k = 0; k < n_hits; k++)
          predicted_matches.insert(predicted_matches.size(), hits[k]);
      end
      default: ;
    endcase
  endtask

  // Compare one observed match with the oldest predicted one.
  task automatic check_match(input result_t got);
    result_t want;
    if (predicted_matches.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected match: id=%h slot=%0d last=%b",
                 got.match_id, got.symbol_slot, got.last_of_byte);
    end else begin
      want = predicted_matches.pop_front();
      if (got.match_id !== want.match_id || got.symbol_slot !== want.symbol_slot ||
          got.last_of_byte !== want.last_of_byte) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("match differs: expected id=%h slot=%0d last=%b, got id=%h slot=%0d last=%b",
                   want.match_id, want.symbol_slot, want.last_of_byte,
                   got.match_id, got.symbol_slot, got.last_of_byte);
      end
    end
  endtask

  // Monitor: note accepted items and check matches on the rising edge.
  always @(posedge clk_i) begin
    item_taken = rst_ni && start && !busy;
    if (rst_ni && result_valid_o) check_match(result_o);
    if (item_taken) walk_automaton(item_i);
  end

  // Gap before the next item: mostly short, a few long, with calm stretches.
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) calm_left = $urandom_range(8, 24);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // Driver: present queued items on the falling edge, holding each until it is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (queued_commands.size() != 0) begin
        item_i    <= queued_commands.pop_front();
        start     <= 1'b1;
        idle_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Fields that the command does not use still carry random bits.
  function automatic item_t noise_item();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(item_t)-1:0];
  endfunction

  task automatic queue_load(input logic [15:0] idx, input logic [15:0] n0, n1, n2, n3,
                            input logic term, input logic [15:0] tag);
    item_t it;
    it               = noise_item();
    it.command       = CMD_LOAD;
    it.node_index    = idx;
    it.next_for_sym0 = n0;
    it.next_for_sym1 = n1;
    it.next_for_sym2 = n2;
    it.next_for_sym3 = n3;
    it.is_terminal   = term;
    it.pattern_tag   = tag;
    queued_commands.insert(queued_commands.size(), it);
  endtask

  // Load a node whose successors all lie among the nodes already loaded or being loaded.
  task automatic queue_random_load(input logic [15:0] idx);
    logic [15:0] nx [0:3];
    for (int s = 0; s < 4; s++) nx[s] = live_nodes[$urandom_range(0, live_nodes.size() - 1)];
    queue_load(idx, nx[0], nx[1], nx[2], nx[3], 1'($urandom_range(0, 1)), 16'($urandom));
  endtask

  task automatic queue_command(input logic [1:0] cmd);
    item_t it;
    it         = noise_item();
    it.command = cmd;
    queued_commands.insert(queued_commands.size(), it);
  endtask

  task automatic queue_data(input logic [7:0] b);
    item_t it;
    it           = noise_item();
    it.command   = CMD_DATA;
    it.data_byte = b;
    queued_commands.insert(queued_commands.size(), it);
  endtask

  // Safety net against a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Build the stimulus, release reset and wait for the scoreboard to drain.
  initial begin
    int pick;
    int counted;
    int n_new;
    int base;

    // Directed part: a four-node automaton on the extreme node ids.
    live_nodes = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};
    queue_load(16'h0000, 16'h0000, 16'h5555, 16'hAAAA, 16'hFFFF, 1'b0, 16'hBEEF);
    queue_load(16'hFFFF, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 1'b1, 16'hFFFF);
    queue_load(16'h5555, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h0000, 1'b1, 16'h0000);
    queue_load(16'hAAAA, 16'h5555, 16'h0000, 16'hAAAA, 16'hFFFF, 1'b1, 16'h1234);
    // Four matches in one byte, then a byte that continues from the last node.
    queue_data(8'hFF);
    queue_data(8'h00);
    // Fresh stream that stays on the root: no match at all.
    queue_command(CMD_START);
    queue_data(8'h00);
    queue_command(CMD_SPARE);
    // Single matches in the first and third slot, scanning on without a start.
    queue_data(8'h70);
    queue_data(8'h0C);
    // Make the root terminal while it is the current node; the load must not move it.
    queue_load(16'h0000, 16'h0000, 16'h5555, 16'hAAAA, 16'hFFFF, 1'b1, 16'h8001);
    queue_data(8'h1B);
    queue_command(CMD_START);
    queue_data(8'hE4);
    // A non-terminal node that still carries a tag must stay silent.
    queue_load(16'h5555, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h0000, 1'b0, 16'hFFFF);
    queue_data(8'h55);
    queue_command(CMD_SPARE);

    // Random part: mostly bytes, with automaton growth, reloads, starts and spare codes.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        n_new = $urandom_range(1, 4);
        base  = live_nodes.size();
        for (int k = 0; k < n_new; k++) live_nodes.insert(live_nodes.size(), 16'($urandom));
        for (int k = base; k < live_nodes.size(); k++) queue_random_load(live_nodes[k]);
        counted += n_new;
      end else if (pick < 12) begin
        queue_random_load(live_nodes[$urandom_range(0, live_nodes.size() - 1)]);
        counted++;
      end else if (pick < 20) begin
        queue_command(CMD_START);
        counted++;
      end else if (pick < 23) begin
        queue_command(CMD_SPARE);
      end else begin
        queue_data(8'($urandom));
        counted++;
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Every item handed over, then every predicted match seen, then a quiet spell.
    while (queued_commands.size() != 0 || start) @(posedge clk_i);
    while (predicted_matches.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0 && predicted_matches.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
